// File: design/gda_pkg.sv
// shared types, constants and calendar helpers for the gregorian date unit
package gda_pkg;

    // year-by-100 divider
    localparam int DIV_W     = 15;
    localparam int REM_W     = 7;
    localparam int DIVISOR   = 100;
    localparam int DIV_RECIP = 5243;   // 2^19 / 100 rounded up, exact for any 15-bit dividend
    localparam int DIV_SHIFT = 19;
    localparam int MUL_W     = 28;

    // working widths
    localparam int YEAR_W = 17;   // signed year during the walk, wide enough for a 24-bit offset
    localparam int M400_W = 9;
    localparam int DN_W   = 23;   // biased day number
    localparam int DIFF_W = 22;

    localparam int DAYS_PER_YEAR = 365;
    localparam int DN_BIAS       = 306;
    localparam int YEAR_SHIFT    = 400;
    localparam int M400_LAST     = 399;

    localparam logic signed [YEAR_W-1:0] YEAR_LO = 17'sd1;
    localparam logic signed [YEAR_W-1:0] YEAR_HI = 17'sd9999;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV,
        S_WALK,
        S_BACK,
        S_DN_MUL,
        S_DN_ADD1,
        S_DN_ADD2
    } t_state;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] v;
        begin
            if (m == 4'd0) begin
                v = 4'd1;
            end else if (m > 4'd12) begin
                v = 4'd12;
            end else begin
                v = m;
            end
            return v;
        end
    endfunction

    // leap from the two low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [M400_W-1:0] m400);
        logic cent;
        begin
            cent = (m400 == 9'd0) || (m400 == 9'd100) || (m400 == 9'd200) || (m400 == 9'd300);
            return ((y_lo == 2'd0) && !cent) || (m400 == 9'd0);
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // (153*mm - 457)/5 with january and february as months 13 and 14
    function automatic logic [8:0] dn_month_term(input logic [3:0] m);
        logic [8:0] t;
        begin
            case (m)
                4'd1:    t = 9'd306;
                4'd2:    t = 9'd337;
                4'd3:    t = 9'd0;
                4'd4:    t = 9'd31;
                4'd5:    t = 9'd61;
                4'd6:    t = 9'd92;
                4'd7:    t = 9'd122;
                4'd8:    t = 9'd153;
                4'd9:    t = 9'd184;
                4'd10:   t = 9'd214;
                4'd11:   t = 9'd245;
                4'd12:   t = 9'd275;
                default: t = 9'd0;
            endcase
            return t;
        end
    endfunction

endpackage

// File: design/gregorian_date_arithmetic_top.sv
// gregorian date unit: shift a date by a signed day count, or take the day difference of two dates
// mode 0: load, divide by 100 for year mod 400, then the walk and a final check; each walk step
//   moves a month forward, or a month back then adds its length; 65535 days walk ~2150 months
// mode 1: two passes of divide by 100 then multiply and two adds per date
// one word at a time: busy stays high from start until the o_valid strobe, then a new word may start
// synchronous active-low reset returns the sequencer and divider to idle; o_valid is a one-cycle
//   strobe and the receiver cannot stall it
module gregorian_date_arithmetic_top #(
    parameter int OFFSET_BITS = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [4:0]                    i_day_in,
    input  logic [3:0]                    i_month_in,
    input  logic [13:0]                   i_year_in,
    input  logic signed [OFFSET_BITS-1:0] i_day_offset,
    input  logic [4:0]                    i_other_day,
    input  logic [3:0]                    i_other_month,
    input  logic [13:0]                   i_other_year,
    output logic                          o_valid,
    output logic [4:0]                    o_day_out,
    output logic [3:0]                    o_month_out,
    output logic [13:0]                   o_year_out,
    output logic [gda_pkg::DIFF_W-1:0]    o_day_difference,
    output logic                          o_range_error
);
    import gda_pkg::*;

    // signed day accumulator: day of month plus the widest offset
    localparam int DW = ((OFFSET_BITS > 6) ? OFFSET_BITS : 6) + 1;

    t_state r_state, n_state;

    // working word
    logic                     r_mode, n_mode;
    logic signed [DW-1:0]     r_d, n_d;
    logic [3:0]               r_m, n_m;
    logic signed [YEAR_W-1:0] r_y, n_y;
    logic [M400_W-1:0]        r_m400, n_m400;
    logic [4:0]               r_d2, n_d2;
    logic [3:0]               r_m2, n_m2;
    logic [13:0]              r_y2, n_y2;
    logic                     r_second, n_second;
    logic [DN_W-1:0]          r_acc, n_acc;
    logic [DN_W-1:0]          r_dn_a, n_dn_a;

    // result registers
    logic                     r_valid, n_valid;
    logic [4:0]               r_day_out, n_day_out;
    logic [3:0]               r_month_out, n_month_out;
    logic [13:0]              r_year_out, n_year_out;
    logic [DIFF_W-1:0]        r_diff, n_diff;
    logic                     r_err, n_err;

    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    logic [4:0]               cur_d;
    logic [3:0]               cur_m;
    logic [13:0]              cur_y;
    logic [DIV_W-1:0]         yy;
    logic [23:0]              prod;
    logic [4:0]               ml;
    logic signed [DW-1:0]     ml_ext;
    logic [DN_W-1:0]          dn_b;
    logic [DN_W-1:0]          abs_diff;
    logic                     accept;

    gda_div100 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // date under the day-number formula: first date, then second
    assign cur_d = r_second ? r_d2 : r_d[4:0];
    assign cur_m = r_second ? r_m2 : r_m;
    assign cur_y = r_second ? r_y2 : r_y[13:0];
    // january and february belong to the previous year; bias by 400 years to stay positive
    assign yy    = DIV_W'({1'b0, cur_y}) - DIV_W'(cur_m < 4'd3) + DIV_W'(YEAR_SHIFT);
    assign prod  = 24'(yy) * 24'(DAYS_PER_YEAR);

    // length of the month the walk stands on
    assign ml     = month_len(r_m, is_leap(r_y[1:0], r_m400));
    assign ml_ext = $signed(DW'(ml));

    assign dn_b     = r_acc + DN_W'(dn_month_term(cur_m)) + DN_W'(cur_d) - DN_W'(DN_BIAS);
    assign abs_diff = (r_dn_a >= dn_b) ? (r_dn_a - dn_b) : (dn_b - r_dn_a);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_d         = r_d;
        n_m         = r_m;
        n_y         = r_y;
        n_m400      = r_m400;
        n_d2        = r_d2;
        n_m2        = r_m2;
        n_y2        = r_y2;
        n_second    = r_second;
        n_acc       = r_acc;
        n_dn_a      = r_dn_a;
        n_valid     = 1'b0;
        n_day_out   = r_day_out;
        n_month_out = r_month_out;
        n_year_out  = r_year_out;
        n_diff      = r_diff;
        n_err       = r_err;
        div_req.go       = 1'b0;
        div_req.dividend = r_mode ? yy : DIV_W'(r_y[13:0]);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // capture the whole word; mode 0 folds the offset into the day at once
                    n_mode   = i_mode;
                    n_d      = i_mode ? $signed(DW'(i_day_in))
                                      : $signed(DW'(i_day_in)) + DW'(i_day_offset);
                    n_m      = clamp_month(i_month_in);
                    n_y      = $signed(YEAR_W'(i_year_in));
                    n_d2     = i_other_day;
                    n_m2     = clamp_month(i_other_month);
                    n_y2     = i_other_year;
                    n_second = 1'b0;
                    n_state  = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                div_req.go = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_mode) begin
                        n_state = S_DN_MUL;
                    end else begin
                        // year mod 400 from quotient and remainder by 100
                        n_m400  = M400_W'(div_rsp.quo[1:0]) * M400_W'(DIVISOR)
                                + M400_W'(div_rsp.rem);
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_d > ml_ext) begin
                    // forward over a whole month
                    n_d = r_d - ml_ext;
                    if (r_m == 4'd12) begin
                        n_m    = 4'd1;
                        n_y    = r_y + 1'b1;
                        n_m400 = (r_m400 == M400_W'(M400_LAST)) ? '0 : r_m400 + 1'b1;
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else if (r_d < $signed(DW'(1))) begin
                    // step back a month, its length is added next cycle
                    if (r_m == 4'd1) begin
                        n_m    = 4'd12;
                        n_y    = r_y - 1'b1;
                        n_m400 = (r_m400 == '0) ? M400_W'(M400_LAST) : r_m400 - 1'b1;
                    end else begin
                        n_m = r_m - 1'b1;
                    end
                    n_state = S_BACK;
                end else begin
                    n_valid     = 1'b1;
                    n_day_out   = r_d[4:0];
                    n_month_out = r_m;
                    n_diff      = '0;
                    if (r_y < YEAR_LO) begin
                        n_err      = 1'b1;
                        n_year_out = 14'(YEAR_LO);
                    end else if (r_y > YEAR_HI) begin
                        n_err      = 1'b1;
                        n_year_out = 14'(YEAR_HI);
                    end else begin
                        n_err      = 1'b0;
                        n_year_out = r_y[13:0];
                    end
                    n_state = S_IDLE;
                end
            end
            S_BACK: begin
                n_d     = r_d + ml_ext;
                n_state = S_WALK;
            end
            S_DN_MUL: begin
                n_acc   = prod[DN_W-1:0];
                n_state = S_DN_ADD1;
            end
            S_DN_ADD1: begin
                // + yy/4 - yy/100 + yy/400
                n_acc   = r_acc + DN_W'(yy >> 2) - DN_W'(div_rsp.quo)
                        + DN_W'(div_rsp.quo >> 2);
                n_state = S_DN_ADD2;
            end
            S_DN_ADD2: begin
                if (!r_second) begin
                    n_dn_a   = dn_b;
                    n_second = 1'b1;
                    n_state  = S_DIV_GO;
                end else begin
                    n_valid     = 1'b1;
                    n_day_out   = '0;
                    n_month_out = '0;
                    n_year_out  = '0;
                    n_err       = 1'b0;
                    n_diff      = abs_diff[DN_W-1] ? {DIFF_W{1'b1}} : abs_diff[DIFF_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_d         <= n_d;
        r_m         <= n_m;
        r_y         <= n_y;
        r_m400      <= n_m400;
        r_d2        <= n_d2;
        r_m2        <= n_m2;
        r_y2        <= n_y2;
        r_second    <= n_second;
        r_acc       <= n_acc;
        r_dn_a      <= n_dn_a;
        r_day_out   <= n_day_out;
        r_month_out <= n_month_out;
        r_year_out  <= n_year_out;
        r_diff      <= n_diff;
        r_err       <= n_err;
    end

    assign o_valid          = r_valid;
    assign o_day_out        = r_day_out;
    assign o_month_out      = r_month_out;
    assign o_year_out       = r_year_out;
    assign o_day_difference = r_diff;
    assign o_range_error    = r_err;

    // an accepted word keeps the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    // a result ends the word: unit is idle while its strobe is shown
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    // the walk always stands on a real month
    a_walk_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_m >= 4'd1 && r_m <= 4'd12))
        else $error("walk month out of range");

    // a range error comes with a saturated year
    a_range_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_year_out == 14'd1 || o_year_out == 14'd9999))
        else $error("range error without saturated year");

    // the divider is only started from the load state
    a_div_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.go |=> (r_state == S_DIV))
        else $error("divider started outside the load state");

endmodule

// File: design/gda_div100.sv
// divide a year value by 100 with a reciprocal multiply: go loads the dividend, then quotient, then remainder and done
module gda_div100 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gda_pkg::t_div_req i_req,
    output gda_pkg::t_div_rsp o_rsp
);
    import gda_pkg::*;

    logic             r_busy, n_busy;
    logic             r_step, n_step;
    logic             r_done, n_done;
    logic [DIV_W-1:0] r_x, n_x;
    logic [DIV_W-1:0] r_dq, n_dq;
    logic [REM_W-1:0] r_dr, n_dr;

    logic [MUL_W-1:0] q_full;
    logic [DIV_W-1:0] q100;

    always_comb begin
        q_full = MUL_W'(r_x) * MUL_W'(DIV_RECIP);
        q100   = r_dq * DIV_W'(DIVISOR);
        n_busy = r_busy;
        n_step = r_step;
        n_done = 1'b0;
        n_x    = r_x;
        n_dq   = r_dq;
        n_dr   = r_dr;
        if (i_req.go) begin
            n_busy = 1'b1;
            n_step = 1'b0;
            n_x    = i_req.dividend;
        end else if (r_busy) begin
            if (!r_step) begin
                // quotient from the scaled reciprocal
                n_dq   = DIV_W'(q_full[MUL_W-1:DIV_SHIFT]);
                n_step = 1'b1;
            end else begin
                n_dr   = REM_W'(r_x - q100);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_done <= n_done;
        end
        r_x  <= n_x;
        r_dq <= n_dq;
        r_dr <= n_dr;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_dq;
    assign o_rsp.rem  = r_dr;

endmodule

// File: bench/tb_gregorian_date_arithmetic_top.sv
// self-checking bench for the gregorian date unit: directed calendar edges, then random words
module tb_gregorian_date_arithmetic_top;

    localparam int OFF_W = 17;
    localparam longint DIFF_CAP = 4194303;
    localparam int STOP_TIME = 50_000_000;    // far beyond 270 full-length backward walks

    // the one mode bit of a word
    typedef enum logic {
        MODE_SHIFT = 1'b0,
        MODE_DIFF  = 1'b1
    } date_mode_e;

    // one command word as it goes onto the ports
    typedef struct {
        date_mode_e              mode;
        logic [4:0]              day;
        logic [3:0]              month;
        logic [13:0]             year;
        logic signed [OFF_W-1:0] offset;
        logic [4:0]              oday;
        logic [3:0]              omonth;
        logic [13:0]             oyear;
    } date_cmd_t;

    // one result word as the strobe presents it
    typedef struct {
        logic [4:0]                 day;
        logic [3:0]                 month;
        logic [13:0]                year;
        logic [gda_pkg::DIFF_W-1:0] diff;
        logic                       range_err;
    } date_result_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_mode;
    logic [4:0]                    i_day_in;
    logic [3:0]                    i_month_in;
    logic [13:0]                   i_year_in;
    logic signed [OFF_W-1:0]       i_day_offset;
    logic [4:0]                    i_other_day;
    logic [3:0]                    i_other_month;
    logic [13:0]                   i_other_year;
    logic                          o_valid;
    logic [4:0]                    o_day_out;
    logic [3:0]                    o_month_out;
    logic [13:0]                   o_year_out;
    logic [gda_pkg::DIFF_W-1:0]    o_day_difference;
    logic                          o_range_error;

    // results predicted at acceptance, oldest first
    date_result_t date_results_due[$];

    int mismatches;
    int shift_words;
    int diff_words;
    int range_flags;
    int capped_diffs;

    gregorian_date_arithmetic_top #(
        .OFFSET_BITS(OFF_W)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_day_in         (i_day_in),
        .i_month_in       (i_month_in),
        .i_year_in        (i_year_in),
        .i_day_offset     (i_day_offset),
        .i_other_day      (i_other_day),
        .i_other_month    (i_other_month),
        .i_other_year     (i_other_year),
        .o_valid          (o_valid),
        .o_day_out        (o_day_out),
        .o_month_out      (o_month_out),
        .o_year_out       (o_year_out),
        .o_day_difference (o_day_difference),
        .o_range_error    (o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // calendar arithmetic used for prediction
    // ------------------------------------------------------------------

    // gregorian rule, also for year 0 and negative years
    function automatic bit leap_rule(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        if (m == 2) begin
            return leap_rule(y) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // month field 0 reads as january, 13..15 as december
    function automatic int fold_month(logic [3:0] m);
        if (m == 4'd0) begin
            return 1;
        end
        if (m > 4'd12) begin
            return 12;
        end
        return int'(m);
    endfunction

    // serial day count; march-based year, shifted 400 years to keep divisions positive
    function automatic longint serial_day(int d, int m, int y);
        longint yy;
        longint mm;
        yy = y;
        mm = m;
        if (mm < 3) begin
            yy -= 1;
            mm += 12;
        end
        yy += 400;
        return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm - 457) / 5 + d - 306;
    endfunction

    // expected result of one accepted word
    function automatic date_result_t compute_date_result(date_cmd_t w);
        date_result_t r;
        int d;
        int m;
        int y;
        int yo;
        longint gap_days;
        r = '{default: '0};
        d = int'(w.day);
        m = fold_month(w.month);
        y = int'(w.year);
        if (w.mode == MODE_SHIFT) begin
            d = d + int'(w.offset);
            // forward walk while the day overruns its month
            while (d > month_days(m, y)) begin
                d -= month_days(m, y);
                m++;
                if (m > 12) begin
                    m = 1;
                    y++;
                end
            end
            // backward walk while the day is below the first
            while (d < 1) begin
                m--;
                if (m < 1) begin
                    m = 12;
                    y--;
                end
                d += month_days(m, y);
            end
            yo = y;
            if (y < 1) begin
                r.range_err = 1'b1;
                yo = 1;
            end else if (y > 9999) begin
                r.range_err = 1'b1;
                yo = 9999;
            end
            r.day   = d[4:0];
            r.month = m[3:0];
            r.year  = yo[13:0];
        end else begin
            gap_days = serial_day(d, m, y)
                     - serial_day(int'(w.oday), fold_month(w.omonth), int'(w.oyear));
            if (gap_days < 0) begin
                gap_days = -gap_days;
            end
            if (gap_days > DIFF_CAP) begin
                gap_days = DIFF_CAP;
            end
            r.diff = gap_days[gda_pkg::DIFF_W-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back or short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // a real calendar date, sometimes close to either end of 1..9999
    function automatic void pick_calendar_date(output logic [4:0] d, output logic [3:0] m,
                                               output logic [13:0] y);
        int yy;
        int mm;
        case ($urandom_range(0, 7))
            0:       yy = $urandom_range(1, 180);
            1:       yy = $urandom_range(9820, 9999);
            default: yy = $urandom_range(1, 9999);
        endcase
        mm = $urandom_range(1, 12);
        d = 5'($urandom_range(1, month_days(mm, yy)));
        m = mm[3:0];
        y = yy[13:0];
    endfunction

    // directed word; the fields the mode ignores still get random values
    function automatic date_cmd_t make_word(date_mode_e mode, int d, int m, int y, int off,
                                            int od, int om, int oy);
        date_cmd_t w;
        w.mode   = mode;
        w.day    = d[4:0];
        w.month  = m[3:0];
        w.year   = y[13:0];
        w.offset = off[OFF_W-1:0];
        w.oday   = od[4:0];
        w.omonth = om[3:0];
        w.oyear  = oy[13:0];
        if (mode == MODE_SHIFT) begin
            w.oday   = 5'($urandom());
            w.omonth = 4'($urandom());
            w.oyear  = 14'($urandom());
        end else begin
            w.offset = OFF_W'($urandom());
        end
        return w;
    endfunction

    // random word: well-formed dates with random content, or raw noise on every field but the mode
    function automatic date_cmd_t random_word(date_mode_e mode, bit wellformed);
        date_cmd_t w;
        int k;
        w.mode   = mode;
        w.offset = OFF_W'($urandom());
        w.oday   = 5'($urandom());
        w.omonth = 4'($urandom());
        w.oyear  = 14'($urandom());
        if (wellformed) begin
            pick_calendar_date(w.day, w.month, w.year);
            if (mode == MODE_DIFF) begin
                pick_calendar_date(w.oday, w.omonth, w.oyear);
                // nearby dates now and then
                if ($urandom_range(0, 3) == 0) begin
                    w.oyear = w.year;
                end
            end else begin
                // short hops dominate, long walks are the expensive minority
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: k = int'($urandom_range(0, 80)) - 40;
                    5, 6, 7:       k = int'($urandom_range(0, 3000)) - 1500;
                    default:       k = int'($urandom_range(0, 131071)) - 65536;
                endcase
                w.offset = k[OFF_W-1:0];
            end
        end else begin
            w.day   = 5'($urandom());
            w.month = 4'($urandom());
            w.year  = 14'($urandom());
        end
        return w;
    endfunction

    // put a word on the ports, hold start until the unit takes it, then idle for gap cycles;
    // with no gap start stays high so the next word follows without a bubble
    task automatic send_word(input date_cmd_t w, input int gap);
        date_result_t r;
        start         <= 1'b1;
        i_mode        <= w.mode;
        i_day_in      <= w.day;
        i_month_in    <= w.month;
        i_year_in     <= w.year;
        i_day_offset  <= w.offset;
        i_other_day   <= w.oday;
        i_other_month <= w.omonth;
        i_other_year  <= w.oyear;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        // accepted at this edge
        r = compute_date_result(w);
        date_results_due.push_back(r);
        if (w.mode == MODE_SHIFT) begin
            shift_words++;
            range_flags += r.range_err;
        end else begin
            diff_words++;
            capped_diffs += (r.diff == DIFF_CAP[gda_pkg::DIFF_W-1:0]);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: every strobe must match the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        date_result_t want;
        if (o_valid === 1'b1) begin
            if (date_results_due.size() == 0) begin
                $error("result word with nothing outstanding");
                mismatches++;
            end else begin
                want = date_results_due.pop_front();
                if (o_day_out !== want.day) begin
                    $error("day_out: expected %0d, got %0d", want.day, o_day_out);
                    mismatches++;
                end
                if (o_month_out !== want.month) begin
                    $error("month_out: expected %0d, got %0d", want.month, o_month_out);
                    mismatches++;
                end
                if (o_year_out !== want.year) begin
                    $error("year_out: expected %0d, got %0d", want.year, o_year_out);
                    mismatches++;
                end
                if (o_day_difference !== want.diff) begin
                    $error("day_difference: expected %0d, got %0d", want.diff,
                           o_day_difference);
                    mismatches++;
                end
                if (o_range_error !== want.range_err) begin
                    $error("range_error: expected %0d, got %0d", want.range_err,
                           o_range_error);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // calendar corners, folded months, odd days, year and offset extremes
    task automatic test_directed_edges();
        // shifts
        send_word(make_word(MODE_SHIFT, 29, 2, 2024, 0, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 31, 12, 2023, 1, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 1, 3, 2024, -1, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 1, 3, 1900, -1, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 28, 2, 2000, 1, 0, 0, 0), idle_cycles());
        // largest forward walk runs past year 9999
        send_word(make_word(MODE_SHIFT, 31, 12, 9999, 65535, 0, 0, 0), idle_cycles());
        // most negative offset the field holds, walks below year 1
        send_word(make_word(MODE_SHIFT, 1, 1, 1, -65536, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 1, 1, 1, -1, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 31, 12, 9999, 1, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 1, 1, 9999, -65535, 0, 0, 0), idle_cycles());
        // day 0 with month 0, then month 15 and a day past february's end
        send_word(make_word(MODE_SHIFT, 0, 0, 2024, 0, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 31, 15, 2024, 0, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 31, 2, 2023, 0, 0, 0, 0), idle_cycles());
        // input years outside 1..9999
        send_word(make_word(MODE_SHIFT, 15, 6, 0, 65535, 0, 0, 0), idle_cycles());
        send_word(make_word(MODE_SHIFT, 31, 12, 16383, -1, 0, 0, 0), idle_cycles());
        // differences
        send_word(make_word(MODE_DIFF, 14, 7, 1789, 0, 14, 7, 1789), idle_cycles());
        send_word(make_word(MODE_DIFF, 1, 1, 1, 0, 31, 12, 9999), idle_cycles());
        send_word(make_word(MODE_DIFF, 31, 12, 16383, 0, 1, 1, 0), idle_cycles());
        send_word(make_word(MODE_DIFF, 0, 0, 2024, 0, 31, 15, 2023), idle_cycles());
        send_word(make_word(MODE_DIFF, 31, 2, 2024, 0, 1, 3, 2024), idle_cycles());
        send_word(make_word(MODE_DIFF, 29, 2, 2024, 0, 1, 3, 2023), idle_cycles());
        send_word(make_word(MODE_DIFF, 1, 1, 2000, 0, 31, 12, 1999), idle_cycles());
    endtask

    task automatic test_random_shifts(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_word(MODE_SHIFT, $urandom_range(0, 99) < 85), idle_cycles());
        end
    endtask

    task automatic test_random_differences(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_word(MODE_DIFF, $urandom_range(0, 99) < 85), idle_cycles());
        end
    endtask

    // no idle at all: start stays high across words
    task automatic test_back_to_back(input int count);
        date_mode_e mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 1) ? MODE_DIFF : MODE_SHIFT;
            send_word(random_word(mode, $urandom_range(0, 99) < 85), 0);
        end
    endtask

    // halfway through, hold off until every outstanding result is back
    task automatic test_drain_then_resume(input int count);
        date_mode_e mode;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                start <= 1'b0;
                wait (date_results_due.size() == 0);
                @(posedge i_clk);
            end
            mode = $urandom_range(0, 1) ? MODE_DIFF : MODE_SHIFT;
            send_word(random_word(mode, $urandom_range(0, 99) < 85), idle_cycles());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatches    = 0;
        shift_words   = 0;
        diff_words    = 0;
        range_flags   = 0;
        capped_diffs  = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_mode        = MODE_SHIFT;
        i_day_in      = '0;
        i_month_in    = '0;
        i_year_in     = '0;
        i_day_offset  = '0;
        i_other_day   = '0;
        i_other_month = '0;
        i_other_year  = '0;

        // synchronous reset, held low and then released
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_directed_edges();
        test_random_shifts(110);
        test_random_differences(80);
        test_back_to_back(40);
        test_drain_then_resume(20);

        // let the last results come home, then watch for strays
        start <= 1'b0;
        wait (date_results_due.size() == 0);
        repeat (60) @(posedge i_clk);

        $display("covered %0d words: %0d date shifts and %0d day differences",
                 shift_words + diff_words, shift_words, diff_words);
        $display("out-of-range result years: %0d, capped differences: %0d, mismatches: %0d",
                 range_flags, capped_diffs, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #STOP_TIME;
        $display("timeout with %0d results outstanding", date_results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
